[rtl/mflg_pkg.sv]
// Package with the constants, codes, payload types and sequencer states of the max-flow unit.
package mflg_pkg;

   localparam int NODES      = 1024;
   localparam int NODE_W     = 10;
   localparam int ARCS       = 8192;
   localparam int ARC_W      = 13;
   localparam int LINK_W     = 14;
   localparam int COUNT_W    = 14;
   localparam int CAP_W      = 16;
   localparam int LVL_W      = 11;
   localparam int SP_W       = 11;
   localparam int LEFT_W     = 31;
   localparam int FLOW_W     = 28;
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;

   localparam logic [LEFT_W-1:0]  PUSH_LIMIT = LEFT_W'(1 << 30);
   localparam logic [FLOW_W-1:0]  FLOW_MAX   = {FLOW_W{1'b1}};
   localparam logic [COUNT_W-1:0] ARC_FULL   = COUNT_W'(ARCS - 2);

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_SOLVE = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_OVERFLOW = 2'd1;
   localparam logic [1:0] ST_SAME     = 2'd2;

   localparam logic [CSR_AW-1:0] REG_SOURCE_ADDR = 3'd0;
   localparam logic [CSR_AW-1:0] REG_SINK_ADDR   = 3'd4;

   typedef struct packed {
      logic [1:0]        operation;
      logic [NODE_W-1:0] from_node;
      logic [NODE_W-1:0] to_node;
      logic [CAP_W-1:0]  capacity;
   } req_type;

   typedef struct packed {
      logic [FLOW_W-1:0] max_flow;
      logic [1:0]        status;
   } rsp_type;

   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic [LINK_W-1:0] link;
      logic [LEFT_W-1:0] left;
      logic [LEFT_W-1:0] got;
      logic [LVL_W-1:0]  lvl;
   } frame_type;

   typedef enum logic [4:0] {
      S_CLR, S_IDLE, S_ADD0, S_ADD1, S_ADD2, S_ADD3,
      S_L_CLR, S_L_SEED, S_L_POP, S_L_U, S_L_FIRST, S_L_ARC, S_L_ARCD, S_L_V, S_L_CHK,
      S_D_INIT, S_D_INIT2, S_D_TOP, S_D_ARC, S_D_CHKV, S_D_NEWF, S_D_RET, S_D_POP,
      S_AP0, S_AP1, S_AP2, S_EMIT
   } state_type;

endpackage

[rtl/mflg_ram.sv]
// Generic single-write, single-read memory with a registered read port.
module mflg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

[rtl/max_flow_level_graph_unit.sv]
// Top level of the max-flow unit: sequencer, graph memories and configuration registers.
// Usage: a request on req_data is taken when req_valid is high and req_stall is low.
// Add-edge requests store an arc pair and link both into the node arc lists, reading and
// writing the node list memory once per end; with the arc table full they set overflow.
// A clear zeroes the arc count and overflow flag, then clears one node list head per cycle.
// A solve runs Dinic's method on a single shared read/compare/update sequencer:
// each level pass first clears 1024 level entries, then a breadth-first walk labels the
// levels and a depth-first push augments along them; the solve time depends on the graph.
// One result, max_flow and status, follows each solve on rsp_data; add and
// clear requests give none. req_stall is high while a request is in progress.
// The result sits in an output register; while rsp_stall holds it, a finished
// solve waits before writing its result, but add and clear requests proceed.
// Reset is synchronous and active high; after it the unit clears all 1024 node list heads
// before it takes the first request.
// source_node and sink_node are written over the APB port at byte addresses 0 and 4.
module max_flow_level_graph_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  mflg_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output mflg_pkg::rsp_type           rsp_data,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [mflg_pkg::CSR_AW-1:0] paddr,
   input  logic [mflg_pkg::CSR_DW-1:0] pwdata,
   output logic [mflg_pkg::CSR_DW-1:0] prdata,
   output logic                        pready
);

   mflg_pkg::state_type state_ff, state_in;
   logic [mflg_pkg::NODE_W-1:0]  cnt_ff, cnt_in;
   logic [mflg_pkg::COUNT_W-1:0] arc_count_ff, arc_count_in;
   logic                         ovf_ff, ovf_in;
   logic [mflg_pkg::NODE_W-1:0]  src_ff, snk_ff;
   logic [mflg_pkg::SP_W-1:0]    qh_ff, qh_in, qt_ff, qt_in, sp_ff, sp_in;
   logic [mflg_pkg::NODE_W-1:0]  top_node_ff, top_node_in;
   logic [mflg_pkg::LINK_W-1:0]  top_link_ff, top_link_in;
   logic [mflg_pkg::LEFT_W-1:0]  top_left_ff, top_left_in, top_got_ff, top_got_in;
   logic [mflg_pkg::LVL_W-1:0]   top_lvl_ff, top_lvl_in;
   logic [mflg_pkg::NODE_W-1:0]  ar_tgt_ff, ar_tgt_in;
   logic [mflg_pkg::CAP_W-1:0]   ar_res_ff, ar_res_in;
   logic [mflg_pkg::LINK_W-1:0]  ar_next_ff, ar_next_in;
   logic [mflg_pkg::ARC_W-1:0]   push_arc_ff, push_arc_in;
   logic [mflg_pkg::CAP_W-1:0]   push_amt_ff, push_amt_in;
   logic [mflg_pkg::FLOW_W-1:0]  total_ff, total_in;
   mflg_pkg::req_type            req_ff, req_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   mflg_pkg::rsp_type            rsp_ff, rsp_in;

   logic                         tgt_we, nxt_we, res_we, arc_re;
   logic [mflg_pkg::ARC_W-1:0]   arc_waddr, arc_raddr, res_waddr, res_raddr;
   logic [mflg_pkg::NODE_W-1:0]  tgt_wdata, tgt_rd;
   logic [mflg_pkg::LINK_W-1:0]  nxt_wdata, nxt_rd;
   logic [mflg_pkg::CAP_W-1:0]   res_wdata, res_rd;
   logic                         first_we, first_re;
   logic [mflg_pkg::NODE_W-1:0]  first_waddr, first_raddr;
   logic [mflg_pkg::LINK_W-1:0]  first_wdata, first_rd;
   logic                         lvl_we, lvl_re;
   logic [mflg_pkg::NODE_W-1:0]  lvl_waddr, lvl_raddr;
   logic [mflg_pkg::LVL_W-1:0]   lvl_wdata, lvl_rd;
   logic                         q_we, q_re;
   logic [mflg_pkg::NODE_W-1:0]  q_waddr, q_raddr, q_wdata, q_rd;
   logic                         stk_we, stk_re;
   logic [mflg_pkg::NODE_W-1:0]  stk_waddr, stk_raddr;
   mflg_pkg::frame_type          stk_wdata, stk_rd;

   logic                         req_take, rsp_free, csr_write;
   logic                         lvl_ok, is_sink, can_push;
   logic [mflg_pkg::CAP_W-1:0]   lim;
   logic [mflg_pkg::LVL_W-1:0]   top_lvl_next;
   logic [mflg_pkg::SP_W-1:0]    sp_dec;
   logic [31:0]                  flow_sum;

   mflg_ram #(.WIDTH(mflg_pkg::NODE_W), .DEPTH(mflg_pkg::ARCS)) u_arc_target (
      .clock(clock), .we(tgt_we), .waddr(arc_waddr), .wdata(tgt_wdata),
      .re(arc_re), .raddr(arc_raddr), .rdata(tgt_rd));
   mflg_ram #(.WIDTH(mflg_pkg::LINK_W), .DEPTH(mflg_pkg::ARCS)) u_arc_next (
      .clock(clock), .we(nxt_we), .waddr(arc_waddr), .wdata(nxt_wdata),
      .re(arc_re), .raddr(arc_raddr), .rdata(nxt_rd));
   mflg_ram #(.WIDTH(mflg_pkg::CAP_W), .DEPTH(mflg_pkg::ARCS)) u_arc_residual (
      .clock(clock), .we(res_we), .waddr(res_waddr), .wdata(res_wdata),
      .re(arc_re), .raddr(res_raddr), .rdata(res_rd));
   mflg_ram #(.WIDTH(mflg_pkg::LINK_W), .DEPTH(mflg_pkg::NODES)) u_node_first (
      .clock(clock), .we(first_we), .waddr(first_waddr), .wdata(first_wdata),
      .re(first_re), .raddr(first_raddr), .rdata(first_rd));
   mflg_ram #(.WIDTH(mflg_pkg::LVL_W), .DEPTH(mflg_pkg::NODES)) u_node_level (
      .clock(clock), .we(lvl_we), .waddr(lvl_waddr), .wdata(lvl_wdata),
      .re(lvl_re), .raddr(lvl_raddr), .rdata(lvl_rd));
   mflg_ram #(.WIDTH(mflg_pkg::NODE_W), .DEPTH(mflg_pkg::NODES)) u_level_queue (
      .clock(clock), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
      .re(q_re), .raddr(q_raddr), .rdata(q_rd));
   mflg_ram #(.WIDTH($bits(mflg_pkg::frame_type)), .DEPTH(mflg_pkg::NODES)) u_search_stack (
      .clock(clock), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
      .re(stk_re), .raddr(stk_raddr), .rdata(stk_rd));

   assign req_stall    = (state_ff != mflg_pkg::S_IDLE);
   assign req_take     = req_valid && !req_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign pready       = 1'b1;
   assign csr_write    = psel && penable && pwrite;
   assign top_lvl_next = mflg_pkg::LVL_W'(top_lvl_ff + 1'b1);
   assign lvl_ok       = (lvl_rd == top_lvl_next) && (ar_res_ff != '0);
   assign is_sink      = (ar_tgt_ff == snk_ff);
   assign can_push     = (sp_ff < mflg_pkg::SP_W'(mflg_pkg::NODES));
   assign lim          = (top_left_ff < mflg_pkg::LEFT_W'(ar_res_ff)) ?
                         top_left_ff[mflg_pkg::CAP_W-1:0] : ar_res_ff;
   assign sp_dec       = mflg_pkg::SP_W'(sp_ff - 1'b1);
   assign flow_sum     = 32'(total_ff) + 32'(top_got_ff);

   always_comb begin
      unique case (paddr)
         mflg_pkg::REG_SOURCE_ADDR: prdata = mflg_pkg::CSR_DW'(src_ff);
         mflg_pkg::REG_SINK_ADDR:   prdata = mflg_pkg::CSR_DW'(snk_ff);
         default:                   prdata = '0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mflg_pkg::S_CLR:     if (cnt_ff == '1) state_in = mflg_pkg::S_IDLE;
         mflg_pkg::S_IDLE: begin
            if (req_take) begin
               unique case (req_data.operation)
                  mflg_pkg::OP_ADD:
                     if (arc_count_ff <= mflg_pkg::ARC_FULL) state_in = mflg_pkg::S_ADD0;
                  mflg_pkg::OP_SOLVE:
                     state_in = (src_ff == snk_ff) ? mflg_pkg::S_EMIT : mflg_pkg::S_L_CLR;
                  mflg_pkg::OP_CLEAR: state_in = mflg_pkg::S_CLR;
                  default:            state_in = mflg_pkg::S_IDLE;
               endcase
            end
         end
         mflg_pkg::S_ADD0:    state_in = mflg_pkg::S_ADD1;
         mflg_pkg::S_ADD1:    state_in = mflg_pkg::S_ADD2;
         mflg_pkg::S_ADD2:    state_in = mflg_pkg::S_ADD3;
         mflg_pkg::S_ADD3:    state_in = mflg_pkg::S_IDLE;
         mflg_pkg::S_L_CLR:   if (cnt_ff == '1) state_in = mflg_pkg::S_L_SEED;
         mflg_pkg::S_L_SEED:  state_in = mflg_pkg::S_L_POP;
         mflg_pkg::S_L_POP:
            state_in = (qh_ff == qt_ff) ? mflg_pkg::S_L_CHK : mflg_pkg::S_L_U;
         mflg_pkg::S_L_U:     state_in = mflg_pkg::S_L_FIRST;
         mflg_pkg::S_L_FIRST: state_in = mflg_pkg::S_L_ARC;
         mflg_pkg::S_L_ARC:
            state_in = (top_link_ff == '0) ? mflg_pkg::S_L_POP : mflg_pkg::S_L_ARCD;
         mflg_pkg::S_L_ARCD:  state_in = mflg_pkg::S_L_V;
         mflg_pkg::S_L_V:     state_in = mflg_pkg::S_L_ARC;
         mflg_pkg::S_L_CHK:
            state_in = (lvl_rd != '0) ? mflg_pkg::S_D_INIT : mflg_pkg::S_EMIT;
         mflg_pkg::S_D_INIT:  state_in = mflg_pkg::S_D_INIT2;
         mflg_pkg::S_D_INIT2: state_in = mflg_pkg::S_D_TOP;
         mflg_pkg::S_D_TOP:
            state_in = (top_link_ff != '0 && top_left_ff != '0) ?
                       mflg_pkg::S_D_ARC : mflg_pkg::S_D_RET;
         mflg_pkg::S_D_ARC:   state_in = mflg_pkg::S_D_CHKV;
         mflg_pkg::S_D_CHKV: begin
            if (lvl_ok && is_sink) state_in = mflg_pkg::S_AP0;
            else if (lvl_ok && can_push) state_in = mflg_pkg::S_D_NEWF;
            else state_in = mflg_pkg::S_D_TOP;
         end
         mflg_pkg::S_D_NEWF:  state_in = mflg_pkg::S_D_TOP;
         mflg_pkg::S_D_RET:
            state_in = (sp_dec == '0) ? mflg_pkg::S_L_CLR : mflg_pkg::S_D_POP;
         mflg_pkg::S_D_POP:   state_in = mflg_pkg::S_AP0;
         mflg_pkg::S_AP0:     state_in = mflg_pkg::S_AP1;
         mflg_pkg::S_AP1:     state_in = mflg_pkg::S_AP2;
         mflg_pkg::S_AP2:     state_in = mflg_pkg::S_D_TOP;
         mflg_pkg::S_EMIT:    if (rsp_free) state_in = mflg_pkg::S_IDLE;
         default:             state_in = mflg_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cnt_in       = cnt_ff;
      arc_count_in = arc_count_ff;
      ovf_in       = ovf_ff;
      qh_in        = qh_ff;
      qt_in        = qt_ff;
      sp_in        = sp_ff;
      top_node_in  = top_node_ff;
      top_link_in  = top_link_ff;
      top_left_in  = top_left_ff;
      top_got_in   = top_got_ff;
      top_lvl_in   = top_lvl_ff;
      ar_tgt_in    = ar_tgt_ff;
      ar_res_in    = ar_res_ff;
      ar_next_in   = ar_next_ff;
      push_arc_in  = push_arc_ff;
      push_amt_in  = push_amt_ff;
      total_in     = total_ff;
      req_in       = req_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      tgt_we      = 1'b0;
      nxt_we      = 1'b0;
      res_we      = 1'b0;
      arc_re      = 1'b0;
      arc_waddr   = arc_count_ff[mflg_pkg::ARC_W-1:0];
      arc_raddr   = '0;
      res_waddr   = arc_count_ff[mflg_pkg::ARC_W-1:0];
      res_raddr   = '0;
      tgt_wdata   = req_ff.to_node;
      nxt_wdata   = first_rd;
      res_wdata   = req_ff.capacity;
      first_we    = 1'b0;
      first_re    = 1'b0;
      first_waddr = cnt_ff;
      first_raddr = '0;
      first_wdata = '0;
      lvl_we      = 1'b0;
      lvl_re      = 1'b0;
      lvl_waddr   = cnt_ff;
      lvl_raddr   = '0;
      lvl_wdata   = '0;
      q_we        = 1'b0;
      q_re        = 1'b0;
      q_waddr     = qt_ff[mflg_pkg::NODE_W-1:0];
      q_raddr     = qh_ff[mflg_pkg::NODE_W-1:0];
      q_wdata     = ar_tgt_ff;
      stk_we      = 1'b0;
      stk_re      = 1'b0;
      stk_waddr   = sp_dec[mflg_pkg::NODE_W-1:0];
      stk_raddr   = mflg_pkg::NODE_W'(sp_dec - 1'b1);
      stk_wdata   = '{node: top_node_ff, link: top_link_ff, left: top_left_ff,
                      got: top_got_ff, lvl: top_lvl_ff};

      unique case (state_ff)
         mflg_pkg::S_CLR: begin
            first_we = 1'b1;
            cnt_in   = mflg_pkg::NODE_W'(cnt_ff + 1'b1);
         end
         mflg_pkg::S_IDLE: begin
            cnt_in = '0;
            req_in = req_data;
            if (req_take) begin
               unique case (req_data.operation)
                  mflg_pkg::OP_ADD:
                     if (arc_count_ff > mflg_pkg::ARC_FULL) ovf_in = 1'b1;
                  mflg_pkg::OP_SOLVE: total_in = '0;
                  mflg_pkg::OP_CLEAR: begin
                     arc_count_in = '0;
                     ovf_in       = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         mflg_pkg::S_ADD0: begin
            first_re    = 1'b1;
            first_raddr = req_ff.from_node;
         end
         mflg_pkg::S_ADD1: begin
            tgt_we      = 1'b1;
            nxt_we      = 1'b1;
            res_we      = 1'b1;
            first_we    = 1'b1;
            first_waddr = req_ff.from_node;
            first_wdata = mflg_pkg::LINK_W'(arc_count_ff + 1'b1);
         end
         mflg_pkg::S_ADD2: begin
            first_re    = 1'b1;
            first_raddr = req_ff.to_node;
         end
         mflg_pkg::S_ADD3: begin
            tgt_we       = 1'b1;
            nxt_we       = 1'b1;
            res_we       = 1'b1;
            arc_waddr    = mflg_pkg::ARC_W'(arc_count_ff + 1'b1);
            res_waddr    = mflg_pkg::ARC_W'(arc_count_ff + 1'b1);
            tgt_wdata    = req_ff.from_node;
            res_wdata    = '0;
            first_we     = 1'b1;
            first_waddr  = req_ff.to_node;
            first_wdata  = mflg_pkg::LINK_W'(arc_count_ff + 2'd2);
            arc_count_in = mflg_pkg::COUNT_W'(arc_count_ff + 2'd2);
         end
         mflg_pkg::S_L_CLR: begin
            lvl_we = 1'b1;
            cnt_in = mflg_pkg::NODE_W'(cnt_ff + 1'b1);
         end
         mflg_pkg::S_L_SEED: begin
            lvl_we    = 1'b1;
            lvl_waddr = src_ff;
            lvl_wdata = mflg_pkg::LVL_W'(1);
            q_we      = 1'b1;
            q_waddr   = '0;
            q_wdata   = src_ff;
            qh_in     = '0;
            qt_in     = mflg_pkg::SP_W'(1);
         end
         mflg_pkg::S_L_POP: begin
            if (qh_ff == qt_ff) begin
               lvl_re    = 1'b1;
               lvl_raddr = snk_ff;
            end else begin
               q_re  = 1'b1;
               qh_in = mflg_pkg::SP_W'(qh_ff + 1'b1);
            end
         end
         mflg_pkg::S_L_U: begin
            first_re    = 1'b1;
            first_raddr = q_rd;
            lvl_re      = 1'b1;
            lvl_raddr   = q_rd;
         end
         mflg_pkg::S_L_FIRST: begin
            top_link_in = first_rd;
            top_lvl_in  = lvl_rd;
         end
         mflg_pkg::S_L_ARC: begin
            arc_re    = 1'b1;
            arc_raddr = mflg_pkg::ARC_W'(top_link_ff - 1'b1);
            res_raddr = mflg_pkg::ARC_W'(top_link_ff - 1'b1);
         end
         mflg_pkg::S_L_ARCD: begin
            ar_tgt_in  = tgt_rd;
            ar_res_in  = res_rd;
            ar_next_in = nxt_rd;
            lvl_re     = 1'b1;
            lvl_raddr  = tgt_rd;
         end
         mflg_pkg::S_L_V: begin
            if (ar_res_ff != '0 && lvl_rd == '0 &&
                qt_ff < mflg_pkg::SP_W'(mflg_pkg::NODES)) begin
               lvl_we    = 1'b1;
               lvl_waddr = ar_tgt_ff;
               lvl_wdata = top_lvl_next;
               q_we      = 1'b1;
               qt_in     = mflg_pkg::SP_W'(qt_ff + 1'b1);
            end
            top_link_in = ar_next_ff;
         end
         mflg_pkg::S_L_CHK: ;
         mflg_pkg::S_D_INIT: begin
            first_re    = 1'b1;
            first_raddr = src_ff;
            lvl_re      = 1'b1;
            lvl_raddr   = src_ff;
         end
         mflg_pkg::S_D_INIT2: begin
            top_node_in = src_ff;
            top_link_in = first_rd;
            top_left_in = mflg_pkg::PUSH_LIMIT;
            top_got_in  = '0;
            top_lvl_in  = lvl_rd;
            sp_in       = mflg_pkg::SP_W'(1);
         end
         mflg_pkg::S_D_TOP: begin
            arc_re    = 1'b1;
            arc_raddr = mflg_pkg::ARC_W'(top_link_ff - 1'b1);
            res_raddr = mflg_pkg::ARC_W'(top_link_ff - 1'b1);
         end
         mflg_pkg::S_D_ARC: begin
            ar_tgt_in  = tgt_rd;
            ar_res_in  = res_rd;
            ar_next_in = nxt_rd;
            lvl_re     = 1'b1;
            lvl_raddr  = tgt_rd;
         end
         mflg_pkg::S_D_CHKV: begin
            if (lvl_ok && is_sink) begin
               push_arc_in = mflg_pkg::ARC_W'(top_link_ff - 1'b1);
               push_amt_in = lim;
            end else if (lvl_ok && can_push) begin
               stk_we      = 1'b1;
               top_node_in = ar_tgt_ff;
               top_left_in = mflg_pkg::LEFT_W'(lim);
               top_got_in  = '0;
               top_lvl_in  = lvl_rd;
               sp_in       = mflg_pkg::SP_W'(sp_ff + 1'b1);
               first_re    = 1'b1;
               first_raddr = ar_tgt_ff;
            end else begin
               top_link_in = ar_next_ff;
            end
         end
         mflg_pkg::S_D_NEWF: top_link_in = first_rd;
         mflg_pkg::S_D_RET: begin
            if (top_got_ff == '0) begin
               lvl_we    = 1'b1;
               lvl_waddr = top_node_ff;
            end
            sp_in = sp_dec;
            if (sp_dec == '0) begin
               total_in = (flow_sum > 32'(mflg_pkg::FLOW_MAX)) ?
                          mflg_pkg::FLOW_MAX : flow_sum[mflg_pkg::FLOW_W-1:0];
               cnt_in   = '0;
            end else begin
               stk_re      = 1'b1;
               push_amt_in = top_got_ff[mflg_pkg::CAP_W-1:0];
            end
         end
         mflg_pkg::S_D_POP: begin
            top_node_in = stk_rd.node;
            top_link_in = stk_rd.link;
            top_left_in = stk_rd.left;
            top_got_in  = stk_rd.got;
            top_lvl_in  = stk_rd.lvl;
            push_arc_in = mflg_pkg::ARC_W'(stk_rd.link - 1'b1);
         end
         mflg_pkg::S_AP0: begin
            arc_re    = 1'b1;
            arc_raddr = push_arc_ff;
            res_raddr = push_arc_ff;
         end
         mflg_pkg::S_AP1: begin
            res_we     = 1'b1;
            res_waddr  = push_arc_ff;
            res_wdata  = mflg_pkg::CAP_W'(res_rd - push_amt_ff);
            arc_re     = 1'b1;
            res_raddr  = push_arc_ff ^ mflg_pkg::ARC_W'(1);
            ar_next_in = nxt_rd;
         end
         mflg_pkg::S_AP2: begin
            res_we      = 1'b1;
            res_waddr   = push_arc_ff ^ mflg_pkg::ARC_W'(1);
            res_wdata   = mflg_pkg::CAP_W'(res_rd + push_amt_ff);
            top_left_in = mflg_pkg::LEFT_W'(top_left_ff - mflg_pkg::LEFT_W'(push_amt_ff));
            top_got_in  = mflg_pkg::LEFT_W'(top_got_ff + mflg_pkg::LEFT_W'(push_amt_ff));
            top_link_in = ar_next_ff;
         end
         mflg_pkg::S_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in.max_flow = total_ff;
               if (src_ff == snk_ff) rsp_in.status = mflg_pkg::ST_SAME;
               else if (ovf_ff) rsp_in.status = mflg_pkg::ST_OVERFLOW;
               else rsp_in.status = mflg_pkg::ST_OK;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mflg_pkg::S_CLR;
         cnt_ff       <= '0;
         arc_count_ff <= '0;
         ovf_ff       <= 1'b0;
         src_ff       <= mflg_pkg::NODE_W'(1);
         snk_ff       <= mflg_pkg::NODE_W'(2);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         arc_count_ff <= arc_count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write && paddr == mflg_pkg::REG_SOURCE_ADDR) begin
            src_ff <= pwdata[mflg_pkg::NODE_W-1:0];
         end
         if (csr_write && paddr == mflg_pkg::REG_SINK_ADDR) begin
            snk_ff <= pwdata[mflg_pkg::NODE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      qh_ff       <= qh_in;
      qt_ff       <= qt_in;
      sp_ff       <= sp_in;
      top_node_ff <= top_node_in;
      top_link_ff <= top_link_in;
      top_left_ff <= top_left_in;
      top_got_ff  <= top_got_in;
      top_lvl_ff  <= top_lvl_in;
      ar_tgt_ff   <= ar_tgt_in;
      ar_res_ff   <= ar_res_in;
      ar_next_ff  <= ar_next_in;
      push_arc_ff <= push_arc_in;
      push_amt_ff <= push_amt_in;
      total_ff    <= total_in;
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
   end

   a_arc_count_even: assert property (@(posedge clock) disable iff (reset)
      arc_count_ff[0] == 1'b0)
      else $error("arc count lost its pairing");

   a_stack_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mflg_pkg::S_D_TOP || state_ff == mflg_pkg::S_D_RET) |-> sp_ff != '0)
      else $error("search stack empty during push phase");

   a_clear_starts: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_data.operation == mflg_pkg::OP_CLEAR) |=> state_ff == mflg_pkg::S_CLR)
      else $error("clear request did not start the sweep");

   a_same_status: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) && rsp_ff.status == mflg_pkg::ST_SAME) |-> src_ff == snk_ff)
      else $error("source-equals-sink status without equal nodes");

endmodule

[tb/tb.sv]
// Self-checking testbench of the max-flow unit: directed and random requests checked by a flow predictor.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 40000000;
   localparam int SETTLE = 1200;
   localparam int ROWS = 17;

   typedef struct {
      mflg_pkg::req_type r;
      bit                known;
      mflg_pkg::rsp_type e;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   mflg_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   mflg_pkg::rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [mflg_pkg::CSR_AW-1:0] paddr = '0;
   logic [mflg_pkg::CSR_DW-1:0] pwdata = '0;
   logic [mflg_pkg::CSR_DW-1:0] prdata;
   logic pready;

   max_flow_level_graph_unit uut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   int unsigned arc_to[mflg_pkg::ARCS], arc_nx[mflg_pkg::ARCS], arc_res[mflg_pkg::ARCS];
   int unsigned head[mflg_pkg::NODES], level[mflg_pkg::NODES], bfs_q[mflg_pkg::NODES];
   int unsigned fr_node[mflg_pkg::NODES], fr_link[mflg_pkg::NODES];
   int unsigned fr_left[mflg_pkg::NODES], fr_got[mflg_pkg::NODES];
   int unsigned arcs_used;
   bit table_full;
   int unsigned src_node = 1, snk_node = 2;

   mflg_pkg::rsp_type flow_q[$];
   int errors = 0;
   int mismatches = 0;
   int send_idle = 0;
   int recv_idle = 0;
   int unsigned cycles = 0;
   int unsigned pool[10];
   row_type rows[ROWS];

   function automatic void graph_clear();
      foreach (head[i]) head[i] = 0;
      arcs_used = 0;
      table_full = 1'b0;
   endfunction

   function automatic void graph_add(int unsigned a, int unsigned b, int unsigned cap);
      if (arcs_used + 2 > mflg_pkg::ARCS) begin
         table_full = 1'b1;
         return;
      end
      arc_to[arcs_used] = b;
      arc_nx[arcs_used] = head[a];
      arc_res[arcs_used] = cap;
      head[a] = arcs_used + 1;
      arc_to[arcs_used + 1] = a;
      arc_nx[arcs_used + 1] = head[b];
      arc_res[arcs_used + 1] = 0;
      head[b] = arcs_used + 2;
      arcs_used += 2;
   endfunction

   function automatic bit label_ok();
      int unsigned qh, qt, u, lk, a, v;
      qh = 0;
      qt = 0;
      foreach (level[i]) level[i] = 0;
      level[src_node] = 1;
      bfs_q[qt++] = src_node;
      while (qh < qt) begin
         u = bfs_q[qh++];
         lk = head[u];
         while (lk != 0) begin
            a = lk - 1;
            v = arc_to[a];
            if (arc_res[a] != 0 && level[v] == 0 && qt < mflg_pkg::NODES) begin
               level[v] = level[u] + 1;
               bfs_q[qt++] = v;
            end
            lk = arc_nx[a];
         end
      end
      return level[snk_node] != 0;
   endfunction

   function automatic void take(int unsigned f, int unsigned a, int unsigned x);
      arc_res[a] -= x;
      arc_res[a ^ 1] += x;
      fr_left[f] -= x;
      fr_got[f] += x;
      fr_link[f] = arc_nx[a];
   endfunction

   function automatic int unsigned push_blocking();
      int unsigned sp, f, u, a, v, lim, got;
      sp = 1;
      fr_node[0] = src_node;
      fr_link[0] = head[src_node];
      fr_left[0] = mflg_pkg::PUSH_LIMIT;
      fr_got[0] = 0;
      forever begin
         f = sp - 1;
         u = fr_node[f];
         if (fr_link[f] != 0 && fr_left[f] > 0) begin
            a = fr_link[f] - 1;
            v = arc_to[a];
            if (level[v] == level[u] + 1 && arc_res[a] != 0) begin
               lim = fr_left[f] < arc_res[a] ? fr_left[f] : arc_res[a];
               if (v == snk_node) begin
                  take(f, a, lim);
                  continue;
               end
               if (sp < mflg_pkg::NODES) begin
                  fr_node[sp] = v;
                  fr_link[sp] = head[v];
                  fr_left[sp] = lim;
                  fr_got[sp] = 0;
                  sp++;
                  continue;
               end
            end
            fr_link[f] = arc_nx[a];
            continue;
         end
         got = fr_got[f];
         if (got == 0) level[u] = 0;
         sp--;
         if (sp == 0) return got;
         take(sp - 1, fr_link[sp - 1] - 1, got);
      end
   endfunction

   function automatic mflg_pkg::rsp_type solve_flow();
      mflg_pkg::rsp_type o;
      longint unsigned total;
      total = 0;
      o.status = table_full ? mflg_pkg::ST_OVERFLOW : mflg_pkg::ST_OK;
      if (src_node == snk_node) o.status = mflg_pkg::ST_SAME;
      else while (label_ok()) total += push_blocking();
      if (total > mflg_pkg::FLOW_MAX) total = mflg_pkg::FLOW_MAX;
      o.max_flow = total[mflg_pkg::FLOW_W-1:0];
      return o;
   endfunction

   function automatic void apply_request(mflg_pkg::req_type r, bit known,
                                         mflg_pkg::rsp_type e);
      mflg_pkg::rsp_type p;
      case (r.operation)
         mflg_pkg::OP_ADD: graph_add(r.from_node, r.to_node, r.capacity);
         mflg_pkg::OP_CLEAR: graph_clear();
         mflg_pkg::OP_SOLVE: begin
            p = solve_flow();
            flow_q.push_back(known ? e : p);
         end
         default: ;
      endcase
   endfunction

   task automatic send(mflg_pkg::req_type r, bit known = 1'b0, mflg_pkg::rsp_type e = '0);
      bit taken;
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      apply_request(r, known, e);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (flow_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(logic [mflg_pkg::CSR_AW-1:0] addr, int unsigned value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == mflg_pkg::REG_SOURCE_ADDR) src_node = value & 10'h3FF;
      else if (addr == mflg_pkg::REG_SINK_ADDR) snk_node = value & 10'h3FF;
   endtask

   task automatic set_ends(int unsigned s, int unsigned t);
      settle();
      csr_write(mflg_pkg::REG_SOURCE_ADDR, s);
      csr_write(mflg_pkg::REG_SINK_ADDR, t);
   endtask

   function automatic mflg_pkg::req_type mkr(logic [1:0] op, int unsigned a, int unsigned b,
                                             int unsigned c);
      mflg_pkg::req_type r;
      r.operation = op;
      r.from_node = mflg_pkg::NODE_W'(a);
      r.to_node = mflg_pkg::NODE_W'(b);
      r.capacity = mflg_pkg::CAP_W'(c);
      return r;
   endfunction

   function automatic mflg_pkg::rsp_type mke(int unsigned flow, logic [1:0] st);
      mflg_pkg::rsp_type e;
      e.max_flow = mflg_pkg::FLOW_W'(flow);
      e.status = st;
      return e;
   endfunction

   function automatic row_type mk(logic [1:0] op, int unsigned a, int unsigned b,
                                  int unsigned c, bit known = 1'b0,
                                  int unsigned flow = 0,
                                  logic [1:0] st = mflg_pkg::ST_OK);
      row_type w;
      w.r = mkr(op, a, b, c);
      w.known = known;
      w.e = mke(flow, st);
      return w;
   endfunction

   function automatic int unsigned pick_node();
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, mflg_pkg::NODES - 1);
      return pool[$urandom_range(0, 9)];
   endfunction

   function automatic mflg_pkg::req_type random_request();
      mflg_pkg::req_type r;
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 7) r.operation = mflg_pkg::OP_SOLVE;
      else if (roll < 9) r.operation = mflg_pkg::OP_CLEAR;
      else if (roll < 10) r.operation = OP_UNUSED;
      else r.operation = mflg_pkg::OP_ADD;
      r.from_node = mflg_pkg::NODE_W'(pick_node());
      r.to_node = mflg_pkg::NODE_W'(pick_node());
      roll = $urandom_range(0, 9);
      if (roll < 7) r.capacity = mflg_pkg::CAP_W'($urandom_range(0, 20));
      else if (roll < 9) r.capacity = mflg_pkg::CAP_W'($urandom_range(0, 65535));
      else r.capacity = 16'hFFFF;
      return r;
   endfunction

   always @(posedge clock) rsp_stall <= !reset && $urandom_range(0, 99) < recv_idle;

   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (flow_q.size() == 0) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result flow=%0d status=%0d",
                        rsp_data.max_flow, rsp_data.status);
         end else begin
            if (rsp_data !== flow_q[0]) begin
               errors++;
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected flow=%0d status=%0d, got flow=%0d status=%0d",
                           flow_q[0].max_flow, flow_q[0].status,
                           rsp_data.max_flow, rsp_data.status);
            end
            void'(flow_q.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   initial begin
      graph_clear();
      rows[0]  = mk(mflg_pkg::OP_SOLVE, 0, 0, 0, 1'b1, 0, mflg_pkg::ST_OK);
      rows[1]  = mk(OP_UNUSED, 1023, 1023, 65535);
      rows[2]  = mk(mflg_pkg::OP_ADD, 1, 2, 65535);
      rows[3]  = mk(mflg_pkg::OP_ADD, 1, 3, 0);
      rows[4]  = mk(mflg_pkg::OP_ADD, 3, 2, 7);
      rows[5]  = mk(mflg_pkg::OP_ADD, 1, 3, 5);
      rows[6]  = mk(mflg_pkg::OP_ADD, 0, 1023, 1);
      rows[7]  = mk(mflg_pkg::OP_ADD, 1023, 0, 65535);
      rows[8]  = mk(mflg_pkg::OP_SOLVE, 0, 0, 0);
      rows[9]  = mk(mflg_pkg::OP_SOLVE, 1023, 1023, 65535);
      rows[10] = mk(mflg_pkg::OP_CLEAR, 0, 0, 0);
      rows[11] = mk(mflg_pkg::OP_ADD, 1, 1, 9);
      rows[12] = mk(mflg_pkg::OP_ADD, 1, 2, 1);
      rows[13] = mk(mflg_pkg::OP_SOLVE, 0, 0, 0);
      rows[14] = mk(mflg_pkg::OP_ADD, 2, 1, 3);
      rows[15] = mk(mflg_pkg::OP_CLEAR, 0, 0, 0);
      rows[16] = mk(mflg_pkg::OP_SOLVE, 0, 0, 0, 1'b1, 0, mflg_pkg::ST_OK);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      foreach (rows[i]) send(rows[i].r, rows[i].known, rows[i].e);

      set_ends(5, 5);
      send(mkr(mflg_pkg::OP_ADD, 5, 6, 4));
      send(mkr(mflg_pkg::OP_SOLVE, 0, 0, 0), 1'b1, mke(0, mflg_pkg::ST_SAME));
      set_ends(1, 2);
      send(mkr(mflg_pkg::OP_CLEAR, 0, 0, 0));
      send(mkr(mflg_pkg::OP_SOLVE, 0, 0, 0), 1'b1, mke(0, mflg_pkg::ST_OK));

      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: set_ends(3, 9);
            1: set_ends(0, 1023);
            default: set_ends(1023, 0);
         endcase
         send_idle = ph == 0 ? 10 : ph == 1 ? 56 : 0;
         recv_idle = ph == 0 ? 56 : ph == 1 ? 10 : 0;
         pool[0] = src_node;
         pool[1] = snk_node;
         for (int k = 2; k < 10; k++) pool[k] = $urandom_range(0, mflg_pkg::NODES - 1);
         for (int n = 0; n < 525; n++) send(random_request());
      end

      settle();
      if (errors == 0 && flow_q.size() == 0) $display("tb OK");
      else $display("tb NOT OK");
      $finish;
   end

endmodule

[max_flow_level_graph_unit.f]
rtl/mflg_pkg.sv
rtl/mflg_ram.sv
rtl/max_flow_level_graph_unit.sv
tb/tb.sv
